FILE: hw/rtl/fbde_pkg.sv
`timescale 1ns / 1ps

package fbde_pkg;

	// screen geometry and store layout
	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;
	localparam int COLOUR_BITS   = 8;
	localparam int PIXELS        = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	// fixed field widths of the channels
	localparam int CMD_W = 3;
	localparam int X_W   = 10;
	localparam int Y_W   = 9;
	localparam int COL_W = 8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SET_BG = 3'd1;
	localparam logic [CMD_W-1:0] CMD_HLINE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_VLINE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RECT   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

	typedef logic [COLOUR_BITS-1:0] pix_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic setup;
		logic clear_step;
		logic fill_step;
		logic scan_step;
		logic read_capture;
		logic res_load;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             empty;
		logic             same_bg;
		logic             read_ok;
		logic             clear_last;
		logic             fill_last;
		logic             scan_last;
		logic             out_free;
	} sts_t;

endpackage

FILE: hw/rtl/fbde_if.sv
`timescale 1ns / 1ps

// command channel
interface fbde_cmd_if;
	import fbde_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [X_W-1:0]   x_start;
	logic [X_W-1:0]   x_stop;
	logic [Y_W-1:0]   y_start;
	logic [Y_W-1:0]   y_stop;
	logic [COL_W-1:0] colour;

	modport source (output valid, command, x_start, x_stop, y_start, y_stop, colour,
		input ready);
	modport sink (input valid, command, x_start, x_stop, y_start, y_stop, colour,
		output ready);
endinterface

// result channel
interface fbde_res_if;
	import fbde_pkg::*;

	logic             valid;
	logic             ready;
	logic             accepted;
	logic [COL_W-1:0] pixel_colour;
	logic [COL_W-1:0] background_out;

	modport source (output valid, accepted, pixel_colour, background_out, input ready);
	modport sink (input valid, accepted, pixel_colour, background_out, output ready);
endinterface

FILE: hw/rtl/fbde_ctrl.sv
`timescale 1ns / 1ps

module fbde_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output fbde_pkg::ctl_t ctl,
	input  fbde_pkg::sts_t sts
);
	import fbde_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SETUP = 4'd2;
	localparam logic [3:0] ST_FILL  = 4'd3;
	localparam logic [3:0] ST_SCAN  = 4'd4;
	localparam logic [3:0] ST_DRAIN = 4'd5;
	localparam logic [3:0] ST_RADDR = 4'd6;
	localparam logic [3:0] ST_RDATA = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// state register, reset starts the store clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				ctl.setup = 1'b1;
				case (sts.cmd)
					CMD_SET_BG: begin
						state_d = sts.same_bg ? ST_DONE : ST_SCAN;
					end
					CMD_HLINE, CMD_VLINE, CMD_RECT: begin
						state_d = sts.empty ? ST_DONE : ST_FILL;
					end
					CMD_READ: begin
						state_d = sts.read_ok ? ST_RADDR : ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_FILL: begin
				ctl.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				ctl.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_RADDR: begin
				state_d = ST_RDATA;
			end
			ST_RDATA: begin
				ctl.read_capture = 1'b1;
				state_d          = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/fbde_dpath.sv
`timescale 1ns / 1ps

module fbde_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbde_pkg::ctl_t                ctl,
	output fbde_pkg::sts_t                sts,
	input  logic [fbde_pkg::CMD_W-1:0]    command,
	input  logic [fbde_pkg::X_W-1:0]      x_start,
	input  logic [fbde_pkg::X_W-1:0]      x_stop,
	input  logic [fbde_pkg::Y_W-1:0]      y_start,
	input  logic [fbde_pkg::Y_W-1:0]      y_stop,
	input  logic [fbde_pkg::COL_W-1:0]    colour,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          accepted,
	output logic [fbde_pkg::COL_W-1:0]    pixel_colour,
	output logic [fbde_pkg::COL_W-1:0]    background_out
);
	import fbde_pkg::*;

	// frame store
	pix_t mem_q [PIXELS];

	// latched command
	logic [CMD_W-1:0]  cmd_q;
	logic [X_W-1:0]    xs_q;
	logic [X_W-1:0]    xhi_q;
	logic [Y_W-1:0]    ys_q;
	logic [Y_W-1:0]    yhi_q;
	pix_t              colour_q;

	// walk counters
	logic [ADDR_W-1:0] row_base_q;
	logic [X_W-1:0]    x_q;
	logic [Y_W-1:0]    y_q;
	logic [ADDR_W-1:0] lin_q;

	// scan pipeline and read data
	logic              scan_vld_s1;
	logic [ADDR_W-1:0] scan_addr_s1;
	pix_t              rd_data_q;
	pix_t              pix_q;
	pix_t              bg_q;

	// result register
	logic              res_vld_q;
	logic              res_acc_q;
	logic [COL_W-1:0]  res_pix_q;
	logic [COL_W-1:0]  res_bg_q;

	logic [X_W-1:0]    x_hi_raw;
	logic [X_W-1:0]    x_hi;
	logic [Y_W-1:0]    y_hi_raw;
	logic [Y_W-1:0]    y_hi;
	logic              lin_last;
	logic              read_ok;
	logic              acc_d;
	logic              we;
	logic [ADDR_W-1:0] wa;
	pix_t              wd;
	logic [ADDR_W-1:0] rd_addr;

	// clip the stop corner to the screen; lines reuse the start coordinate
	always_comb begin
		x_hi_raw = (command == CMD_VLINE) ? x_start : x_stop;
		y_hi_raw = (command == CMD_HLINE) ? y_start : y_stop;
		x_hi = (32'(x_hi_raw) > 32'(SCREEN_WIDTH - 1)) ? X_W'(SCREEN_WIDTH - 1) : x_hi_raw;
		y_hi = (32'(y_hi_raw) > 32'(SCREEN_HEIGHT - 1)) ? Y_W'(SCREEN_HEIGHT - 1) : y_hi_raw;
	end

	// command latch
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= command;
			xs_q     <= x_start;
			xhi_q    <= x_hi;
			ys_q     <= y_start;
			yhi_q    <= y_hi;
			colour_q <= COLOUR_BITS'(colour);
		end
	end

	// status
	assign lin_last = (lin_q == ADDR_W'(PIXELS - 1));
	assign read_ok  = (32'(xs_q) < 32'(SCREEN_WIDTH)) && (32'(ys_q) < 32'(SCREEN_HEIGHT));

	always_comb begin
		sts.cmd        = cmd_q;
		sts.empty      = (xs_q > xhi_q) || (ys_q > yhi_q);
		sts.same_bg    = (colour_q == bg_q);
		sts.read_ok    = read_ok;
		sts.clear_last = lin_last;
		sts.fill_last  = (x_q == xhi_q) && (y_q == yhi_q);
		sts.scan_last  = lin_last;
		sts.out_free   = !res_vld_q || res_ready;
	end

	// rectangle walk, row base advances by one screen line per row
	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			x_q        <= xs_q;
			y_q        <= ys_q;
			row_base_q <= ADDR_W'(32'(ys_q) * SCREEN_WIDTH);
		end else if (ctl.fill_step) begin
			if (x_q == xhi_q) begin
				x_q        <= xs_q;
				y_q        <= y_q + Y_W'(1);
				row_base_q <= row_base_q + ADDR_W'(SCREEN_WIDTH);
			end else begin
				x_q <= x_q + X_W'(1);
			end
		end
	end

	// linear sweep counter for clearing and background repaint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q       <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			if (ctl.clear_step || ctl.scan_step) begin
				lin_q <= lin_last ? '0 : lin_q + ADDR_W'(1);
			end
			scan_vld_s1 <= ctl.scan_step;
		end
	end

	always_ff @(posedge clk) begin
		scan_addr_s1 <= lin_q;
	end

	// store write port: clear, fill, or repaint of a matching pixel
	always_comb begin
		we = 1'b0;
		wa = lin_q;
		wd = '0;
		if (ctl.clear_step) begin
			we = 1'b1;
		end else if (ctl.fill_step) begin
			we = 1'b1;
			wa = row_base_q + ADDR_W'(x_q);
			wd = colour_q;
		end else if (scan_vld_s1 && (rd_data_q == bg_q)) begin
			we = 1'b1;
			wa = scan_addr_s1;
			wd = colour_q;
		end
	end

	assign rd_addr = ctl.scan_step ? lin_q : row_base_q + ADDR_W'(xs_q);

	// store write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
	end

	// store read, registered
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.read_capture) begin
			pix_q <= rd_data_q;
		end
	end

	// result flags
	always_comb begin
		case (cmd_q)
			CMD_SET_BG, CMD_HLINE, CMD_VLINE, CMD_RECT: acc_d = 1'b1;
			CMD_READ:                                  acc_d = read_ok;
			default:                                   acc_d = 1'b0;
		endcase
	end

	// background register and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q      <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (ctl.res_load && (cmd_q == CMD_SET_BG)) begin
				bg_q <= colour_q;
			end
			if (ctl.res_load) begin
				res_vld_q <= 1'b1;
			end else if (res_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			res_acc_q <= acc_d;
			res_pix_q <= ((cmd_q == CMD_READ) && read_ok) ? COL_W'(pix_q) : '0;
			res_bg_q  <= (cmd_q == CMD_SET_BG) ? COL_W'(colour_q) : COL_W'(bg_q);
		end
	end

	assign res_valid      = res_vld_q;
	assign accepted       = res_acc_q;
	assign pixel_colour   = res_pix_q;
	assign background_out = res_bg_q;

endmodule

FILE: hw/rtl/framebuffer_draw_engine_unit.sv
`timescale 1ns / 1ps
// framebuffer draw engine: fills lines and rectangles in a 640x480 store of
// 8-bit colour codes, repaints the background and reads single pixels.
// cmd channel: one beat per command (code, two corners, colour); res channel:
// one beat per command with accepted flag, pixel colour and background.
// commands run one at a time; cmd.ready is high only while the engine is idle.
// fill commands write the clipped area one pixel per cycle; set background
// with a new colour runs a read-compare-write sweep of the whole store; read
// pixel reads one stored pixel; rejected, empty or unchanged-background
// commands go straight to the result. the rate is set by the single write
// port of the frame store: one pixel per cycle.
// the result sits in an output register; the next command is taken while it
// waits, and a stalled receiver only holds up the finish of that next command.
// reset: the store is cleared by a sweep of all 307200 pixels, one pixel a
// cycle, with cmd.ready low; the background colour resets to zero.
module framebuffer_draw_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	fbde_cmd_if.sink    cmd,
	fbde_res_if.source  res
);
	import fbde_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic in_ready;

	assign cmd.ready = in_ready;

	// control sequencer
	fbde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// frame store, walkers and result register
	fbde_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.command        (cmd.command),
		.x_start        (cmd.x_start),
		.x_stop         (cmd.x_stop),
		.y_start        (cmd.y_start),
		.y_stop         (cmd.y_stop),
		.colour         (cmd.colour),
		.res_valid      (res.valid),
		.res_ready      (res.ready),
		.accepted       (res.accepted),
		.pixel_colour   (res.pixel_colour),
		.background_out (res.background_out)
	);

endmodule

FILE: hw/rtl/fbde_checker.sv
`timescale 1ns / 1ps

module fbde_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic                       res_accepted,
	input logic [fbde_pkg::COL_W-1:0] res_pixel_colour
);

	// a result beat stays offered until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped before it was taken");

	// one command at a time: ready falls after every accepted beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while another is in progress");

	// a rejected command reports no pixel
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_accepted |-> res_pixel_colour == '0)
		else $error("rejected command carries a pixel colour");

	// nothing offered or taken once reset has been seen at an edge
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !res_valid && !cmd_ready)
		else $error("channel active during reset");

endmodule

bind framebuffer_draw_engine_unit fbde_checker u_fbde_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_accepted     (res.accepted),
	.res_pixel_colour (res.pixel_colour)
);
